FILE: rtl/core/sfs_pkg.sv
`default_nettype none
package sfs_pkg;
    localparam int ENTRY_COUNT_DEF = 8;
    localparam int FRAME_BITS_DEF = 12;

    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_DEFINE = 4'd1, OP_REMOVE = 4'd2, OP_CLEAR = 4'd3,
        OP_PLAY = 4'd4, OP_PLAY_NEW = 4'd5, OP_STOP = 4'd6, OP_PAUSE = 4'd7,
        OP_RESUME = 4'd8, OP_QUERY = 4'd9
    } t_op;

    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_FB_EN = 3'd1;
    localparam logic [2:0] REG_FB_ENTRY = 3'd2;
    localparam logic [2:0] REG_CELL_W = 3'd3;
    localparam logic [2:0] REG_CELL_H = 3'd4;
    localparam logic [2:0] REG_COLUMNS = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_ACC, ST_DIV1, ST_SETUP2, ST_DIV2, ST_FIN,
        ST_FBRD, ST_FB, ST_RDIV, ST_MUL, ST_OUT
    } t_state;

    // request and quotient/remainder response of a 32-bit serial divide
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [31:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

FILE: rtl/core/sfs_div.sv
`default_nettype none
module sfs_div
    import sfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic [5:0]  r_cnt;
    logic [32:0] w_t;

    always_comb begin
        w_t = {r_r[31:0], r_q[31]};
        n_q = {r_q[30:0], 1'b0};
        n_r = w_t;
        if (w_t >= {1'b0, r_d}) begin
            n_r = w_t - {1'b0, r_d};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
        if (i_req.start) begin
            r_q <= i_req.num;
            r_r <= '0;
            r_d <= i_req.den;
        end else if (r_cnt != 6'd0) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_rsp.busy = (r_cnt != 6'd0);
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r[31:0];
endmodule
`default_nettype wire

FILE: rtl/core/sfs_table.sv
`default_nettype none
module sfs_table
    import sfs_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1,
    localparam int DW = 2 * FRAME_BITS + 17
)
(
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output logic [DW-1:0]      o_rdata
);
    logic [DW-1:0] r_mem [ENTRY_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/sprite_frame_sequencer.sv
`default_nettype none
// Sprite frame sequencer: an entry table of ENTRY_COUNT animations in a
// registered-read memory, plus the playback state. One item at a time; every
// item ends with a 32-bit serial divide of the shown frame by the sheet
// columns for the cell row/column. A tick adds one divide for the frame
// advance, and a looping entry one more for the wrap. An output register
// holds the result, and the next item is taken while it waits.
// Configure only while idle with no result waiting.
module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [2:0]  i_entry_index,
    input  wire logic [15:0] i_elapsed,
    input  wire logic [11:0] i_first_frame,
    input  wire logic [11:0] i_frame_total,
    input  wire logic [15:0] i_frame_period,
    input  wire logic        i_repeat_flag,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic [12:0]      o_sheet_frame,
    output logic             o_rect_valid,
    output logic [17:0]      o_rect_x,
    output logic [23:0]      o_rect_y,
    output logic             o_is_playing,
    output logic             o_is_done,
    output logic [7:0]       o_loop_events,
    output logic             o_done_event,
    output logic             o_start_event,
    output logic             o_entry_present
);
    localparam int ENTRY_COUNT = ENTRY_COUNT_DEF;
    localparam int FRAME_BITS = FRAME_BITS_DEF;
    localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int FB = FRAME_BITS;
    localparam int DW = 2 * FB + 17;
    localparam int SW = FB + 1;

    // config
    logic [15:0] r_speed;
    logic        r_fb_en;
    logic [2:0]  r_fb_entry;
    logic [9:0]  r_cell_w, r_cell_h;
    logic [7:0]  r_cols;

    // state
    t_state r_st, n_st;
    logic [ENTRY_COUNT-1:0] r_vld, n_vld;
    logic [IW-1:0] r_act, n_act;
    logic r_aset, n_aset, r_run, n_run, r_done, n_done;
    logic [FB-1:0] r_lf, n_lf;
    logic [31:0] r_acc, n_acc;
    logic [SW-1:0] r_shown, n_shown;

    // item
    logic [3:0]  r_op;
    logic [2:0]  r_idx;
    logic [15:0] r_el;
    logic [FB-1:0] r_ff, r_ft;
    logic [15:0] r_fp;
    logic r_rep;
    logic r_stat, n_stat, r_pres, n_pres, r_dev, n_dev, r_sev, n_sev;
    logic [7:0] r_loops, n_loops;
    logic [31:0] r_tmp, n_tmp;   // saturated acc, then row product
    logic [31:0] r_n, n_n;       // frames advanced
    logic [31:0] r_prod, n_prod;

    // output
    logic r_ov;

    // table
    logic we;
    logic [IW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [FB-1:0] e_first, e_total;
    logic [15:0] e_period;
    logic e_rep;

    t_div_req dreq;
    t_div_rsp drsp;

    sfs_table #(.ENTRY_COUNT(ENTRY_COUNT), .FRAME_BITS(FRAME_BITS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    sfs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    assign {e_first, e_total, e_period, e_rep} = rdata;

    function automatic logic def_ok(input logic [2:0] idx,
                                    input logic [ENTRY_COUNT-1:0] v);
        logic r;
        r = 1'b0;
        if (32'(idx) < ENTRY_COUNT) r = v[idx[IW-1:0]];
        return r;
    endfunction

    wire in_acc  = i_valid && !o_stall;
    wire out_acc = r_ov && !i_stall;
    assign o_stall = (r_st != ST_IDLE);
    assign o_cfg_ready = (r_st == ST_IDLE) && !r_ov && !i_valid;
    assign o_valid = r_ov;

    wire rect_ok = (r_cols != 8'd0) && (r_cell_w != 10'd0) && (r_cell_h != 10'd0);
    wire [31:0] el_prod = {16'd0, r_el} * {16'd0, r_speed};
    wire [32:0] sum_acc = {1'b0, r_acc} + {1'b0, el_prod};
    wire [31:0] step = {8'd0, e_period, 8'd0};
    wire [32:0] pos = 33'(r_lf) + 33'(r_n);

    always_comb begin
        n_st = r_st; n_vld = r_vld; n_act = r_act; n_aset = r_aset;
        n_run = r_run; n_done = r_done; n_lf = r_lf; n_acc = r_acc;
        n_shown = r_shown; n_stat = r_stat; n_pres = r_pres; n_dev = r_dev;
        n_sev = r_sev; n_loops = r_loops; n_tmp = r_tmp; n_n = r_n;
        n_prod = r_prod;
        we = 1'b0; waddr = r_idx[IW-1:0];
        wdata = {r_ff, r_ft, r_fp, r_rep};
        raddr = r_act;
        dreq = '0;
        unique case (r_st)
            ST_IDLE: begin
                if (in_acc) begin
                    n_st = ST_RD;
                    n_stat = 1'b0; n_pres = 1'b0; n_dev = 1'b0; n_sev = 1'b0;
                    n_loops = '0;
                end
                raddr = (i_opcode == OP_TICK || i_opcode == OP_REMOVE ||
                         i_opcode == OP_CLEAR || i_opcode == OP_STOP) ?
                        r_act : i_entry_index[IW-1:0];
            end
            ST_RD: begin
                n_st = ST_RDIV;
                unique case (r_op)
                    OP_TICK: begin
                        if (r_run && r_aset && r_vld[r_act]) begin
                            n_st = ST_ACC;
                        end
                    end
                    OP_DEFINE: begin
                        if (r_ft == '0 || r_fp == 16'd0 || def_ok(r_idx, r_vld) ||
                            32'(r_idx) >= ENTRY_COUNT) begin
                            n_stat = 1'b1;
                        end else begin
                            we = 1'b1;
                            n_vld[r_idx[IW-1:0]] = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_aset && 32'(r_act) == 32'(r_idx)) begin
                            if (r_vld[r_act]) n_shown = SW'(e_first);
                            n_lf = '0; n_acc = '0; n_run = 1'b0; n_done = 1'b0;
                        end
                        if (def_ok(r_idx, r_vld)) n_vld[r_idx[IW-1:0]] = 1'b0;
                        else n_stat = 1'b1;
                    end
                    OP_CLEAR, OP_STOP: begin
                        if (r_aset && r_vld[r_act]) n_shown = SW'(e_first);
                        n_lf = '0; n_acc = '0; n_run = 1'b0; n_done = 1'b0;
                        if (r_op == OP_CLEAR) n_vld = '0;
                    end
                    OP_PLAY, OP_PLAY_NEW: begin
                        if (r_op == OP_PLAY_NEW && r_aset &&
                            32'(r_act) == 32'(r_idx) && r_run) begin
                        end else if (def_ok(r_idx, r_vld)) begin
                            n_act = r_idx[IW-1:0]; n_aset = 1'b1; n_lf = '0;
                            n_acc = '0; n_run = 1'b1; n_done = 1'b0;
                            n_shown = SW'(e_first); n_sev = 1'b1;
                        end else begin
                            n_stat = 1'b1;
                        end
                    end
                    OP_PAUSE: n_run = 1'b0;
                    OP_RESUME: if (!r_run && r_aset && !r_done) n_run = 1'b1;
                    OP_QUERY: n_pres = def_ok(r_idx, r_vld);
                    default: n_stat = 1'b1;
                endcase
            end
            ST_ACC: begin
                n_tmp = sum_acc[32] ? 32'hFFFF_FFFF : sum_acc[31:0];
                dreq.start = 1'b1;
                dreq.num = sum_acc[32] ? 32'hFFFF_FFFF : sum_acc[31:0];
                dreq.den = step;
                n_st = ST_DIV1;
            end
            ST_DIV1: begin
                if (!drsp.busy) begin
                    n_n = drsp.quo;
                    n_acc = drsp.rem;
                    n_st = e_rep ? ST_SETUP2 : ST_FIN;
                end
            end
            ST_SETUP2: begin
                dreq.start = 1'b1;
                dreq.num = pos[31:0];
                dreq.den = 32'(e_total);
                n_st = ST_DIV2;
            end
            ST_DIV2: begin
                if (!drsp.busy) begin
                    n_loops = (drsp.quo > 32'd255) ? 8'd255 : drsp.quo[7:0];
                    n_lf = drsp.rem[FB-1:0];
                    n_shown = SW'(e_first) + SW'(drsp.rem[FB-1:0]);
                    n_st = ST_RDIV;
                end
            end
            ST_FIN: begin
                n_st = ST_RDIV;
                if (pos >= 33'(e_total)) begin
                    n_acc = r_tmp - (32'(e_total - r_lf) * step);
                    n_lf = e_total - FB'(1);
                    n_run = 1'b0; n_done = 1'b1; n_dev = 1'b1;
                    n_shown = SW'(e_first) + SW'(e_total - FB'(1));
                    if (r_fb_en) begin
                        raddr = r_fb_entry[IW-1:0];
                        n_st = ST_FBRD;
                    end
                end else begin
                    n_lf = r_lf + r_n[FB-1:0];
                    n_shown = SW'(e_first) + SW'(r_lf + r_n[FB-1:0]);
                end
            end
            ST_FBRD: begin
                raddr = r_fb_entry[IW-1:0];
                n_st = ST_FB;
            end
            ST_FB: begin
                if (def_ok(r_fb_entry, r_vld)) begin
                    n_act = r_fb_entry[IW-1:0]; n_aset = 1'b1; n_lf = '0;
                    n_acc = '0; n_run = 1'b1; n_done = 1'b0;
                    n_shown = SW'(e_first); n_sev = 1'b1;
                end
                n_st = ST_RDIV;
            end
            ST_RDIV: begin
                dreq.start = 1'b1;
                dreq.num = 32'(r_shown);
                dreq.den = 32'(r_cols);
                n_st = ST_MUL;
            end
            ST_MUL: begin
                if (!drsp.busy) begin
                    n_prod = 32'(drsp.rem[7:0]) * 32'(r_cell_w);
                    n_tmp = 32'(drsp.quo[SW-1:0]) * 32'(r_cell_h);
                    n_st = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || out_acc) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_vld <= '0; r_act <= '0; r_aset <= 1'b0;
            r_run <= 1'b0; r_done <= 1'b0; r_lf <= '0; r_acc <= '0;
            r_shown <= '0; r_ov <= 1'b0;
            r_speed <= 16'd256; r_fb_en <= 1'b0; r_fb_entry <= '0;
            r_cell_w <= '0; r_cell_h <= '0; r_cols <= '0;
        end else begin
            r_st <= n_st; r_vld <= n_vld; r_act <= n_act; r_aset <= n_aset;
            r_run <= n_run; r_done <= n_done; r_lf <= n_lf; r_acc <= n_acc;
            r_shown <= n_shown;
            if (r_st == ST_OUT && (!r_ov || out_acc)) r_ov <= 1'b1;
            else if (out_acc) r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_SPEED:    r_speed <= i_cfg_data;
                    REG_FB_EN:    r_fb_en <= i_cfg_data[0];
                    REG_FB_ENTRY: r_fb_entry <= i_cfg_data[2:0];
                    REG_CELL_W:   r_cell_w <= i_cfg_data[9:0];
                    REG_CELL_H:   r_cell_h <= i_cfg_data[9:0];
                    REG_COLUMNS:  r_cols <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        r_stat <= n_stat; r_pres <= n_pres; r_dev <= n_dev; r_sev <= n_sev;
        r_loops <= n_loops; r_tmp <= n_tmp; r_n <= n_n; r_prod <= n_prod;
        if (in_acc) begin
            r_op <= i_opcode; r_idx <= i_entry_index; r_el <= i_elapsed;
            r_ff <= i_first_frame[FB-1:0]; r_ft <= i_frame_total[FB-1:0];
            r_fp <= i_frame_period; r_rep <= i_repeat_flag;
        end
        if (r_st == ST_OUT && (!r_ov || out_acc)) begin
            o_status <= r_stat;
            o_sheet_frame <= 13'(r_shown);
            o_rect_valid <= rect_ok;
            o_rect_x <= rect_ok ? r_prod[17:0] : 18'd0;
            o_rect_y <= rect_ok ? r_tmp[23:0] : 24'd0;
            o_is_playing <= r_run; o_is_done <= r_done;
            o_loop_events <= r_loops; o_done_event <= r_dev;
            o_start_event <= r_sev; o_entry_present <= r_pres;
        end
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_done)) else $error("running and done");
    a_ov_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov) else $error("result dropped");
endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sfs_pkg::*;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  index;
        logic [15:0] elapsed;
        logic [11:0] first;
        logic [11:0] total;
        logic [15:0] period;
        logic        rep;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [12:0] frame;
        logic        rvalid;
        logic [17:0] rx;
        logic [23:0] ry;
        logic        playing;
        logic        done;
        logic [7:0]  loops;
        logic        done_ev;
        logic        start_ev;
        logic        present;
    } t_frame_out;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    t_cmd cur = '0;
    wire in_stall, cfg_ready, out_valid;
    t_frame_out got;

    sprite_frame_sequencer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_opcode(cur.opcode), .i_entry_index(cur.index), .i_elapsed(cur.elapsed),
        .i_first_frame(cur.first), .i_frame_total(cur.total),
        .i_frame_period(cur.period), .i_repeat_flag(cur.rep),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(got.status), .o_sheet_frame(got.frame), .o_rect_valid(got.rvalid),
        .o_rect_x(got.rx), .o_rect_y(got.ry), .o_is_playing(got.playing),
        .o_is_done(got.done), .o_loop_events(got.loops), .o_done_event(got.done_ev),
        .o_start_event(got.start_ev), .o_entry_present(got.present)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic        tbl_valid [8];
    logic [11:0] tbl_first [8];
    logic [11:0] tbl_total [8];
    logic [15:0] tbl_period [8];
    logic        tbl_rep [8];
    logic [2:0]  act_entry;
    logic        act_set, is_running, is_finished;
    logic [11:0] cur_local;
    logic [31:0] accum;
    logic [12:0] shown;
    logic [15:0] speed;
    logic        fb_en;
    logic [2:0]  fb_entry;
    logic [9:0]  cell_w, cell_h;
    logic [7:0]  columns;

    t_cmd pending_cmds[$];
    t_frame_out expected_frames[$];
    int idle_pct = 0, stall_pct = 0;
    int hold_off = 0;
    bit hold_req = 0, hold_used = 0;
    bit in_taken = 0;
    int errors = 0, quiet = 0;

    function automatic void stop_playback();
        if (act_set && tbl_valid[act_entry]) shown = {1'b0, tbl_first[act_entry]};
        cur_local = '0;
        accum = '0;
        is_running = 0;
        is_finished = 0;
    endfunction

    function automatic bit start_entry(logic [2:0] idx);
        if (!tbl_valid[idx]) return 0;
        act_entry = idx;
        act_set = 1;
        cur_local = '0;
        accum = '0;
        is_running = 1;
        is_finished = 0;
        shown = {1'b0, tbl_first[idx]};
        return 1;
    endfunction

    function automatic t_frame_out predict_frame(t_cmd c);
        t_frame_out r;
        logic [63:0] stp, acc, n, pos, w, k;
        r = '0;
        case (c.opcode)
            OP_TICK: begin
                if (is_running && act_set && tbl_valid[act_entry]) begin
                    stp = 64'(tbl_period[act_entry]) << 8;
                    acc = 64'(accum) + 64'(c.elapsed) * 64'(speed);
                    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                    n = acc / stp;
                    if (tbl_rep[act_entry]) begin
                        pos = 64'(cur_local) + n;
                        w = pos / 64'(tbl_total[act_entry]);
                        r.loops = (w > 255) ? 8'd255 : w[7:0];
                        cur_local = 12'(pos % 64'(tbl_total[act_entry]));
                        accum = 32'(acc - n * stp);
                        shown = 13'(tbl_first[act_entry]) + 13'(cur_local);
                    end else if (64'(cur_local) + n >= 64'(tbl_total[act_entry])) begin
                        k = 64'(tbl_total[act_entry]) - 64'(cur_local);
                        accum = 32'(acc - k * stp);
                        cur_local = tbl_total[act_entry] - 12'd1;
                        is_running = 0;
                        is_finished = 1;
                        r.done_ev = 1;
                        shown = 13'(tbl_first[act_entry]) + 13'(cur_local);
                        if (fb_en && start_entry(fb_entry)) r.start_ev = 1;
                    end else begin
                        cur_local = cur_local + 12'(n);
                        accum = 32'(acc - n * stp);
                        shown = 13'(tbl_first[act_entry]) + 13'(cur_local);
                    end
                end
            end
            OP_DEFINE: begin
                if (c.total == 0 || c.period == 0 || tbl_valid[c.index]) r.status = 1;
                else begin
                    tbl_valid[c.index] = 1;
                    tbl_first[c.index] = c.first;
                    tbl_total[c.index] = c.total;
                    tbl_period[c.index] = c.period;
                    tbl_rep[c.index] = c.rep;
                end
            end
            OP_REMOVE: begin
                if (act_set && act_entry == c.index) stop_playback();
                if (tbl_valid[c.index]) tbl_valid[c.index] = 0;
                else r.status = 1;
            end
            OP_CLEAR: begin
                stop_playback();
                for (int i = 0; i < 8; i++) tbl_valid[i] = 0;
            end
            OP_PLAY: if (start_entry(c.index)) r.start_ev = 1; else r.status = 1;
            OP_PLAY_NEW: begin
                if (!(act_set && act_entry == c.index && is_running)) begin
                    if (start_entry(c.index)) r.start_ev = 1; else r.status = 1;
                end
            end
            OP_STOP: stop_playback();
            OP_PAUSE: is_running = 0;
            OP_RESUME: if (!is_running && act_set && !is_finished) is_running = 1;
            OP_QUERY: r.present = tbl_valid[c.index];
            default: r.status = 1;
        endcase
        r.frame = shown;
        if (columns != 0 && cell_w != 0 && cell_h != 0) begin
            r.rvalid = 1;
            r.rx = 18'((32'(shown) % 32'(columns)) * 32'(cell_w));
            r.ry = 24'((32'(shown) / 32'(columns)) * 32'(cell_h));
        end
        r.playing = is_running;
        r.done = is_finished;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_req && !hold_used) begin
                hold_used <= 1'b1;
                hold_off <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (in_valid && !in_stall) begin
                expected_frames.push_back(predict_frame(cur));
            end
            if (out_valid && !out_stall) begin
                if (expected_frames.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item %p", got);
                end else if (got !== expected_frames[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %p got %p", expected_frames[0], got);
                    void'(expected_frames.pop_front());
                end else begin
                    void'(expected_frames.pop_front());
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SPEED: speed = val;
            REG_FB_EN: fb_en = val[0];
            REG_FB_ENTRY: fb_entry = val[2:0];
            REG_CELL_W: cell_w = val[9:0];
            REG_CELL_H: cell_h = val[9:0];
            REG_COLUMNS: columns = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_frames.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_cmd mk(logic [3:0] op, logic [2:0] idx, logic [15:0] el = 0,
                                logic [11:0] f = 0, logic [11:0] t = 0,
                                logic [15:0] p = 0, logic rp = 0);
        t_cmd c;
        c.opcode = op; c.index = idx; c.elapsed = el; c.first = f;
        c.total = t; c.period = p; c.rep = rp;
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(99);
        c = t_cmd'({$urandom, $urandom});
        if (r < 45) begin
            c.opcode = OP_TICK;
            c.elapsed = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        end else if (r < 60) begin
            c.opcode = OP_DEFINE;
            if ($urandom_range(7) != 0) begin
                c.total = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 8));
                c.period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            end
        end else if (r < 75) c.opcode = ($urandom_range(1)) ? OP_PLAY : OP_PLAY_NEW;
        else if (r < 97) c.opcode = 4'($urandom_range(2, 9));
        else c.opcode = 4'($urandom_range(10, 15));
        return c;
    endfunction

    initial begin
        for (int i = 0; i < 8; i++) begin
            tbl_valid[i] = 0; tbl_first[i] = 0; tbl_total[i] = 0;
            tbl_period[i] = 0; tbl_rep[i] = 0;
        end
        act_entry = 0; act_set = 0; is_running = 0; is_finished = 0;
        cur_local = 0; accum = 0; shown = 0;
        speed = 256; fb_en = 0; fb_entry = 0; cell_w = 0; cell_h = 0; columns = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_CELL_W, 16'd1023);
        write_reg(REG_CELL_H, 16'd1023);
        write_reg(REG_COLUMNS, 16'd255);
        write_reg(REG_FB_EN, 16'd1);
        write_reg(REG_FB_ENTRY, 16'd7);

        // directed
        pending_cmds.push_back(mk(OP_TICK, 0, 16'hFFFF));
        pending_cmds.push_back(mk(OP_QUERY, 7));
        pending_cmds.push_back(mk(OP_DEFINE, 0, 0, 12'd10, 12'd0, 16'd5));
        pending_cmds.push_back(mk(OP_DEFINE, 0, 0, 12'd10, 12'd3, 16'd0));
        pending_cmds.push_back(mk(OP_DEFINE, 0, 0, 12'hFFF, 12'hFFF, 16'hFFFF, 1));
        pending_cmds.push_back(mk(OP_DEFINE, 0, 0, 12'd1, 12'd1, 16'd1));
        pending_cmds.push_back(mk(OP_DEFINE, 7, 0, 12'd300, 12'd4, 16'd2, 1));
        pending_cmds.push_back(mk(OP_DEFINE, 1, 0, 12'd20, 12'd3, 16'd1, 0));
        pending_cmds.push_back(mk(OP_QUERY, 7));
        pending_cmds.push_back(mk(OP_PLAY, 3));
        pending_cmds.push_back(mk(OP_PLAY, 1));
        pending_cmds.push_back(mk(OP_TICK, 0, 16'd1));
        pending_cmds.push_back(mk(OP_TICK, 0, 16'd5));
        pending_cmds.push_back(mk(OP_TICK, 0, 16'hFFFF));
        pending_cmds.push_back(mk(OP_PLAY_NEW, 7));
        pending_cmds.push_back(mk(OP_PAUSE, 0));
        pending_cmds.push_back(mk(OP_TICK, 0, 16'd9));
        pending_cmds.push_back(mk(OP_RESUME, 0));
        pending_cmds.push_back(mk(OP_PLAY_NEW, 0));
        pending_cmds.push_back(mk(OP_TICK, 0, 16'hFFFF));
        pending_cmds.push_back(mk(OP_STOP, 0));
        pending_cmds.push_back(mk(OP_REMOVE, 0));
        pending_cmds.push_back(mk(OP_REMOVE, 0));
        pending_cmds.push_back(mk(4'd15, 0));
        pending_cmds.push_back(mk(OP_CLEAR, 0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_SPEED, 16'hFFFF);
                    write_reg(REG_FB_EN, 16'd0);
                end
                1: begin
                    write_reg(REG_SPEED, 16'd0);
                    write_reg(REG_CELL_W, 16'd0);
                end
                2: begin
                    write_reg(REG_SPEED, 16'($urandom_range(64, 1024)));
                    write_reg(REG_CELL_W, 16'($urandom_range(1, 1023)));
                    write_reg(REG_CELL_H, 16'($urandom_range(1, 1023)));
                    write_reg(REG_COLUMNS, 16'($urandom_range(1, 16)));
                    write_reg(REG_FB_EN, 16'd1);
                    write_reg(REG_FB_ENTRY, 16'($urandom_range(7)));
                end
                3: write_reg(REG_COLUMNS, 16'd1);
                4: write_reg(REG_SPEED, 16'd256);
                default: begin
                    write_reg(REG_FB_ENTRY, 16'd0);
                    write_reg(REG_CELL_H, 16'd1);
                end
            endcase
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 50; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 50; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int i = 0; i < 270; i++) pending_cmds.push_back(rand_cmd());
            if (ph == 0) hold_req = 1;
            drain();
        end
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

FILE: sprite_frame_sequencer.f
rtl/core/sfs_pkg.sv
rtl/core/sfs_div.sv
rtl/core/sfs_table.sv
rtl/core/sprite_frame_sequencer.sv
test/testbench.sv
